// ===== hdl/bap_pkg.sv =====
`timescale 1ns / 1ps
package bap_pkg;

  localparam int FB = 24;
  localparam int IN_W = 17;
  localparam int QNH_W = 11;
  localparam int E_W = 5;
  localparam int M_W = FB + 1;
  localparam int DEN_W = FB + 2;
  localparam int S_W = 23;
  localparam int DIV_STEPS = S_W;
  localparam int LN_TERMS = 12;
  localparam int SUM_W = 24;
  localparam int LN_W = 28;
  localparam int Y_W = 23;
  localparam int TM_W = FB + 1;
  localparam int EXP_TERMS = 12;
  localparam int ESUM_W = 27;
  localparam int DM_W = 23;
  localparam int X_W = 20;
  localparam int FT_W = 15;
  localparam int MT_W = 14;

  localparam logic [IN_W-1:0] P_MIN = 17'd30000;
  localparam logic [QNH_W-1:0] QNH_MIN = 11'd900;
  localparam logic [QNH_W-1:0] QNH_MAX = 11'd1100;
  localparam logic [QNH_W-1:0] QNH_RESET = 11'd1013;
  localparam logic [6:0] HPA_TO_PA = 7'd100;

  localparam logic [FB-1:0] LN2_Q = 24'hB17218;
  localparam logic [21:0] C019 = 22'd3187671;
  localparam logic [20:0] FT_NUM = 21'd1454422;
  localparam logic [20:0] M_NUM = 21'd443308;
  localparam logic [31:0] RECIP10 = 32'd429496730;
  localparam logic [FT_W-1:0] FT_MAX = 15'h7FFF;
  localparam logic [MT_W-1:0] M_MAX = 14'h3FFF;

  // ceil(2^32 / d) for the odd ln divisors 2k+1, entry 0 unused
  localparam logic [31:0] LN_RECIP [LN_TERMS] = '{
    32'd0,
    32'(((64'd1 << 32) + 64'd2) / 64'd3),
    32'(((64'd1 << 32) + 64'd4) / 64'd5),
    32'(((64'd1 << 32) + 64'd6) / 64'd7),
    32'(((64'd1 << 32) + 64'd8) / 64'd9),
    32'(((64'd1 << 32) + 64'd10) / 64'd11),
    32'(((64'd1 << 32) + 64'd12) / 64'd13),
    32'(((64'd1 << 32) + 64'd14) / 64'd15),
    32'(((64'd1 << 32) + 64'd16) / 64'd17),
    32'(((64'd1 << 32) + 64'd18) / 64'd19),
    32'(((64'd1 << 32) + 64'd20) / 64'd21),
    32'(((64'd1 << 32) + 64'd22) / 64'd23)
  };

  // ceil(2^32 / k) for the exp term index k, entries 0 and 1 unused
  localparam logic [31:0] EXP_RECIP [EXP_TERMS+1] = '{
    32'd0,
    32'd0,
    32'(((64'd1 << 32) + 64'd1) / 64'd2),
    32'(((64'd1 << 32) + 64'd2) / 64'd3),
    32'(((64'd1 << 32) + 64'd3) / 64'd4),
    32'(((64'd1 << 32) + 64'd4) / 64'd5),
    32'(((64'd1 << 32) + 64'd5) / 64'd6),
    32'(((64'd1 << 32) + 64'd6) / 64'd7),
    32'(((64'd1 << 32) + 64'd7) / 64'd8),
    32'(((64'd1 << 32) + 64'd8) / 64'd9),
    32'(((64'd1 << 32) + 64'd9) / 64'd10),
    32'(((64'd1 << 32) + 64'd10) / 64'd11),
    32'(((64'd1 << 32) + 64'd11) / 64'd12)
  };

  typedef struct packed {
    logic [FT_W-1:0] ft;
    logic            ft_under;
    logic [MT_W-1:0] mt;
    logic            m_under;
  } result_t;

endpackage

// ===== hdl/bap_ln.sv =====
`timescale 1ns / 1ps
module bap_ln import bap_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [IN_W-1:0] in_val,
  output logic            out_v,
  output logic [LN_W-1:0] out_ln
);

  logic [E_W-1:0] e_nxt;
  logic [M_W-1:0] m_nxt;
  logic [IN_W+FB-1:0] wide;

  logic           a_v_r;
  logic [E_W-1:0] a_e_r;
  logic [M_W-1:0] a_m_r;

  logic             d_v_r   [DIV_STEPS+1];
  logic [E_W-1:0]   d_e_r   [DIV_STEPS+1];
  logic [DEN_W-1:0] d_rem_r [DIV_STEPS+1];
  logic [DEN_W-1:0] d_den_r [DIV_STEPS+1];
  logic [S_W-1:0]   d_q_r   [DIV_STEPS+1];
  logic [DEN_W-1:0] rem_nxt [DIV_STEPS+1];
  logic [S_W-1:0]   q_nxt   [DIV_STEPS+1];

  logic             s_v_r   [LN_TERMS+1];
  logic [E_W-1:0]   s_e_r   [LN_TERMS+1];
  logic [S_W-1:0]   s_s2_r  [LN_TERMS+1];
  logic [S_W-1:0]   s_t_r   [LN_TERMS+1];
  logic [SUM_W-1:0] s_sum_r [LN_TERMS+1];
  logic [S_W-1:0]   t_nxt   [LN_TERMS+1];
  logic [SUM_W-1:0] sum_nxt [LN_TERMS+1];

  logic [2*S_W-1:0] sq;
  logic             f_v_r;
  logic [LN_W-1:0]  f_ln_r;

  // leading one and mantissa
  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (in_val[i]) begin
        e_nxt = E_W'(i);
      end
    end
    wide = {in_val, {FB{1'b0}}} >> e_nxt;
    m_nxt = wide[M_W-1:0];
  end

  // restoring divide steps, one quotient bit each
  always_comb begin
    rem_nxt[0] = '0;
    q_nxt[0] = '0;
    for (int j = 1; j <= DIV_STEPS; j++) begin
      logic [DEN_W:0] sh;
      logic ge;
      sh = {d_rem_r[j-1], 1'b0};
      ge = (sh >= {1'b0, d_den_r[j-1]});
      rem_nxt[j] = ge ? DEN_W'(sh - {1'b0, d_den_r[j-1]}) : DEN_W'(sh);
      q_nxt[j] = {d_q_r[j-1][S_W-2:0], ge};
    end
  end

  assign sq = d_q_r[DIV_STEPS] * d_q_r[DIV_STEPS];

  // series terms t_k / (2k+1)
  always_comb begin
    t_nxt[0] = '0;
    sum_nxt[0] = '0;
    for (int k = 1; k <= LN_TERMS; k++) begin
      logic [S_W+32-1:0] pr;
      logic [2*S_W-1:0] tp;
      pr = s_t_r[k-1] * LN_RECIP[k-1];
      tp = s_t_r[k-1] * s_s2_r[k-1];
      if (k == 1) begin
        sum_nxt[k] = s_sum_r[k-1] + SUM_W'(s_t_r[k-1]);
      end else begin
        sum_nxt[k] = s_sum_r[k-1] + SUM_W'(pr[S_W+31:32]);
      end
      t_nxt[k] = S_W'(tp[2*S_W-1:FB]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      f_v_r <= 1'b0;
      for (int j = 0; j <= DIV_STEPS; j++) d_v_r[j] <= 1'b0;
      for (int k = 0; k <= LN_TERMS; k++) s_v_r[k] <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      d_v_r[0] <= a_v_r;
      for (int j = 1; j <= DIV_STEPS; j++) d_v_r[j] <= d_v_r[j-1];
      s_v_r[0] <= d_v_r[DIV_STEPS];
      for (int k = 1; k <= LN_TERMS; k++) s_v_r[k] <= s_v_r[k-1];
      f_v_r <= s_v_r[LN_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_e_r <= e_nxt;
      a_m_r <= m_nxt;
      d_e_r[0] <= a_e_r;
      d_den_r[0] <= DEN_W'(a_m_r) + (DEN_W'(1) << FB);
      d_rem_r[0] <= DEN_W'({a_m_r[FB-1:0], 1'b0});
      d_q_r[0] <= '0;
      for (int j = 1; j <= DIV_STEPS; j++) begin
        d_e_r[j] <= d_e_r[j-1];
        d_den_r[j] <= d_den_r[j-1];
        d_rem_r[j] <= rem_nxt[j];
        d_q_r[j] <= q_nxt[j];
      end
      s_e_r[0] <= d_e_r[DIV_STEPS];
      s_t_r[0] <= d_q_r[DIV_STEPS];
      s_s2_r[0] <= S_W'(sq[2*S_W-1:FB]);
      s_sum_r[0] <= '0;
      for (int k = 1; k <= LN_TERMS; k++) begin
        s_e_r[k] <= s_e_r[k-1];
        s_s2_r[k] <= s_s2_r[k-1];
        s_t_r[k] <= t_nxt[k];
        s_sum_r[k] <= sum_nxt[k];
      end
      f_ln_r <= LN_W'(s_e_r[LN_TERMS] * LN2_Q) + LN_W'({s_sum_r[LN_TERMS], 1'b0});
    end
  end

  assign out_v = f_v_r;
  assign out_ln = f_ln_r;

endmodule

// ===== hdl/bap_exp.sv =====
`timescale 1ns / 1ps
module bap_exp import bap_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic [LN_W-1:0]          in_lnp,
  input  logic [LN_W-1:0]          in_lnq,
  output logic                     out_v,
  output logic signed [ESUM_W-1:0] out_d
);

  logic signed [LN_W:0] l;
  logic                 x_v_r;
  logic                 x_neg_r;
  logic [LN_W-1:0]      x_mag_r;
  logic [LN_W+22-1:0]   yp;

  logic                     t_v_r   [EXP_TERMS+1];
  logic                     t_neg_r [EXP_TERMS+1];
  logic [Y_W-1:0]           t_ym_r  [EXP_TERMS+1];
  logic [TM_W-1:0]          t_tm_r  [EXP_TERMS+1];
  logic signed [ESUM_W-1:0] t_sum_r [EXP_TERMS+1];

  logic                     x2_v_r   [EXP_TERMS];
  logic                     x2_neg_r [EXP_TERMS];
  logic [Y_W-1:0]           x2_ym_r  [EXP_TERMS];
  logic [Y_W-1:0]           x2_x_r   [EXP_TERMS];
  logic signed [ESUM_W-1:0] x2_sum_r [EXP_TERMS];

  logic [Y_W-1:0]           mx_nxt  [EXP_TERMS];
  logic [TM_W-1:0]          tm_nxt  [EXP_TERMS];
  logic signed [ESUM_W-1:0] sum_nxt [EXP_TERMS];

  assign l = $signed({1'b0, in_lnp}) - $signed({1'b0, in_lnq});
  assign yp = x_mag_r * C019;

  always_comb begin
    for (int i = 0; i < EXP_TERMS; i++) begin
      logic [TM_W+Y_W-1:0] p;
      logic [Y_W+32-1:0] r;
      logic signed [ESUM_W-1:0] ts;
      p = t_tm_r[i] * t_ym_r[i];
      mx_nxt[i] = p[FB+Y_W-1:FB];
      r = x2_x_r[i] * EXP_RECIP[i+1];
      if (i == 0) begin
        tm_nxt[i] = TM_W'(x2_x_r[i]);
      end else begin
        tm_nxt[i] = TM_W'(r[Y_W+31:32]);
      end
      ts = $signed(ESUM_W'(tm_nxt[i]));
      // odd terms subtract for a negative exponent
      if (x2_neg_r[i] && (i % 2 == 0)) begin
        sum_nxt[i] = x2_sum_r[i] - ts;
      end else begin
        sum_nxt[i] = x2_sum_r[i] + ts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r <= 1'b0;
      for (int i = 0; i <= EXP_TERMS; i++) t_v_r[i] <= 1'b0;
      for (int i = 0; i < EXP_TERMS; i++) x2_v_r[i] <= 1'b0;
    end else if (en) begin
      x_v_r <= in_v;
      t_v_r[0] <= x_v_r;
      for (int i = 0; i < EXP_TERMS; i++) begin
        x2_v_r[i] <= t_v_r[i];
        t_v_r[i+1] <= x2_v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_neg_r <= l[LN_W];
      x_mag_r <= l[LN_W] ? LN_W'(-l) : LN_W'(l);
      t_neg_r[0] <= x_neg_r;
      t_ym_r[0] <= yp[FB+Y_W-1:FB];
      t_tm_r[0] <= TM_W'(1) << FB;
      t_sum_r[0] <= $signed(ESUM_W'(1) << FB);
      for (int i = 0; i < EXP_TERMS; i++) begin
        x2_neg_r[i] <= t_neg_r[i];
        x2_ym_r[i] <= t_ym_r[i];
        x2_x_r[i] <= mx_nxt[i];
        x2_sum_r[i] <= t_sum_r[i];
        t_neg_r[i+1] <= x2_neg_r[i];
        t_ym_r[i+1] <= x2_ym_r[i];
        t_tm_r[i+1] <= tm_nxt[i];
        t_sum_r[i+1] <= sum_nxt[i];
      end
    end
  end

  assign out_v = t_v_r[EXP_TERMS];
  assign out_d = $signed(ESUM_W'(1) << FB) - t_sum_r[EXP_TERMS];

endmodule

// ===== hdl/bap_scale.sv =====
`timescale 1ns / 1ps
module bap_scale import bap_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic signed [ESUM_W-1:0] in_d,
  output logic                     out_v,
  output result_t                  out_res
);

  logic [DM_W-1:0]    dm;
  logic               a_v_r, a_pos_r;
  logic [DM_W+20:0]   a_pf_r, a_pm_r;
  logic               b_v_r, b_pos_r;
  logic [X_W+31:0]    qf, qm;
  logic [X_W-1:0]     b_qf_r, b_qm_r;
  logic               c_v_r;
  result_t            c_res_r;
  result_t            res_nxt;

  assign dm = in_d[DM_W-1:0];
  assign qf = a_pf_r[DM_W+20:FB] * RECIP10;
  assign qm = a_pm_r[DM_W+20:FB] * RECIP10;

  always_comb begin
    res_nxt.ft_under = !b_pos_r || (b_qf_r == '0);
    res_nxt.m_under = !b_pos_r || (b_qm_r == '0);
    if (res_nxt.ft_under) begin
      res_nxt.ft = '0;
    end else if (b_qf_r > X_W'(FT_MAX)) begin
      res_nxt.ft = FT_MAX;
    end else begin
      res_nxt.ft = b_qf_r[FT_W-1:0];
    end
    if (res_nxt.m_under) begin
      res_nxt.mt = '0;
    end else if (b_qm_r > X_W'(M_MAX)) begin
      res_nxt.mt = M_MAX;
    end else begin
      res_nxt.mt = b_qm_r[MT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pos_r <= (in_d > 0);
      a_pf_r <= dm * FT_NUM;
      a_pm_r <= dm * M_NUM;
      b_pos_r <= a_pos_r;
      b_qf_r <= qf[X_W+31:32];
      b_qm_r <= qm[X_W+31:32];
      c_res_r <= res_nxt;
    end
  end

  assign out_v = c_v_r;
  assign out_res = c_res_r;

endmodule

// ===== hdl/baro_altitude_from_pressure.sv =====
`timescale 1ns / 1ps
// path: an input word passes in order through the log pipeline, the power pipeline, the
// scale pipeline and the output register
// throughput: one word per cycle; the pipeline stalls as a whole only when the
// output register and its skid stage both hold words
// reset: rst_n synchronous active low, clears all valid bits and sets qnh_hpa to 1013
module baro_altitude_from_pressure import bap_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   in_pressure_pa,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FT_W-1:0]   out_altitude_ft,
  output logic              out_ft_under,
  output logic [MT_W-1:0]   out_altitude_m,
  output logic              out_m_under,
  input  logic              cfg_we,
  input  logic [QNH_W-1:0]  cfg_qnh_hpa
);

  logic [QNH_W-1:0] qnh_r;
  logic [QNH_W-1:0] qc;
  logic [QNH_W+6:0] q100;
  logic [IN_W-1:0]  pc;
  logic             en;
  logic             lp_v, lq_v, e_v, s_v;
  logic [LN_W-1:0]  lnp, lnq;
  logic signed [ESUM_W-1:0] d;
  result_t          s_res;
  result_t          out_r, skid_r;
  logic             out_v_r, skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qnh_r <= QNH_RESET;
    end else if (cfg_we) begin
      qnh_r <= cfg_qnh_hpa;
    end
  end

  always_comb begin
    if (qnh_r < QNH_MIN) begin
      qc = QNH_MIN;
    end else if (qnh_r > QNH_MAX) begin
      qc = QNH_MAX;
    end else begin
      qc = qnh_r;
    end
    q100 = qc * HPA_TO_PA;
    pc = (in_pressure_pa < P_MIN) ? P_MIN : in_pressure_pa;
  end

  assign en = !skid_v_r;
  assign in_ready = en;

  bap_ln u_ln_p (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid && en),
    .in_val(pc), .out_v(lp_v), .out_ln(lnp)
  );

  bap_ln u_ln_q (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid && en),
    .in_val(IN_W'(q100)), .out_v(lq_v), .out_ln(lnq)
  );

  bap_exp u_exp (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(lp_v),
    .in_lnp(lnp), .in_lnq(lnq), .out_v(e_v), .out_d(d)
  );

  bap_scale u_scale (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(e_v),
    .in_d(d), .out_v(s_v), .out_res(s_res)
  );

  // output word register with one skid word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_r <= skid_r;
        out_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_r <= s_res;
        out_v_r <= s_v;
      end
    end else if (s_v && en) begin
      skid_r <= s_res;
      skid_v_r <= 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_altitude_ft = out_r.ft;
  assign out_ft_under = out_r.ft_under;
  assign out_altitude_m = out_r.mt;
  assign out_m_under = out_r.m_under;

  a_ln_sync: assert property (@(posedge clk) disable iff (!rst_n) lp_v == lq_v)
    else $error("log pipelines out of step");

  a_skid_out: assert property (@(posedge clk) disable iff (!rst_n) skid_v_r |-> out_v_r)
    else $error("skid word without output word");

  a_ft_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ft_under) |-> (out_altitude_ft == '0))
    else $error("feet under with nonzero altitude");

  a_m_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_m_under) |-> (out_altitude_m == '0))
    else $error("metre under with nonzero altitude");

endmodule
